/* hw/rtl/fidtlv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fidtlv_pkg
// Shared types, codes and tables for the remote id vendor element parser.
// ----------------------------------------------------------------------------
package fidtlv_pkg;

  // id characters kept per record kind
  localparam int MAX_ID_CHARS  = 20;
  // first record header inside the element
  localparam int FIRST_HEADER  = 6;
  // operator id characters begin this far into the record value
  localparam int ID_CHAR_OFFSET = 6;
  // record types that capture a field
  localparam int CAPTURE_TYPES = 8;
  localparam int FIELD_SLOTS   = 4;
  // results held between parser and consumer
  localparam int QUEUE_DEPTH   = 2;

  // record type codes
  localparam logic [7:0] REC_OPERATOR_ID   = 8'd2;
  localparam logic [7:0] REC_UAV_ID        = 8'd3;
  localparam logic [7:0] REC_FIRST_CAPTURE = 8'd4;
  localparam logic [7:0] REC_LAST_CAPTURE  = 8'd11;

  typedef enum logic [1:0] {
    KIND_OPERATOR_CHAR = 2'd0,
    KIND_UAV_CHAR      = 2'd1,
    KIND_SUMMARY       = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_element;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [4:0]         char_index;
    logic [7:0]         char_value;
    logic signed [31:0] uav_lat;
    logic signed [31:0] uav_lon;
    logic signed [31:0] operator_lat;
    logic signed [31:0] operator_long;
    logic signed [15:0] altitude;
    logic signed [15:0] height;
    logic [7:0]         ground_speed;
    logic [15:0]        course;
  } result_t;

  // bytes captured for each field record, indexed by type minus four
  function automatic logic [2:0] cap_size(input logic [2:0] k);
    logic [2:0] s;
    unique case (k)
      3'd0, 3'd1, 3'd4, 3'd5: s = 3'd4;
      3'd6:                   s = 3'd1;
      default:                s = 3'd2;
    endcase
    return s;
  endfunction

  // storage slot of each field record
  function automatic logic [1:0] cap_slot(input logic [2:0] k);
    logic [1:0] s;
    unique case (k)
      3'd0, 3'd2: s = 2'd0;
      3'd1, 3'd3: s = 2'd1;
      3'd4, 3'd6: s = 2'd2;
      default:    s = 2'd3;
    endcase
    return s;
  endfunction

  // wide (32-bit) or narrow (16-bit) storage
  function automatic logic cap_wide(input logic [2:0] k);
    logic w;
    unique case (k)
      3'd0, 3'd1, 3'd4, 3'd5: w = 1'b1;
      default:                w = 1'b0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/french_remote_id_tlv_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// french_remote_id_tlv_parser
// Result beats are registered in the result queue and read from its head.
// Throughput: one byte per cycle unless full; the byte parser is combinational,
//   and full rises only when the result queue holds QUEUE_DEPTH beats.
// Reset: synchronous rst clears the parse state, all fields and the queue.
// ----------------------------------------------------------------------------
module french_remote_id_tlv_parser #(
  parameter int QUEUE_DEPTH = fidtlv_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire fidtlv_pkg::in_item_t element_byte,
  output logic                      empty,
  input  wire logic                 pop,
  output fidtlv_pkg::result_t       result
);

  logic                accept;
  logic                res_valid;
  fidtlv_pkg::result_t res_item;

  // a byte is taken whenever the queue has room for its result
  assign accept = push && !full;

  // parser front
  fidtlv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_item   (element_byte),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // result queue
  fidtlv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_valid),
    .wr_item (res_item),
    .rd      (pop),
    .rd_item (result),
    .empty   (empty),
    .full    (full)
  );

endmodule
`default_nettype wire

/* hw/rtl/fidtlv_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fidtlv_front
// Byte parser: walks the records of one element, captures the big-endian
// fields and classifies each beat into an id character, a summary or nothing.
// ----------------------------------------------------------------------------
module fidtlv_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire fidtlv_pkg::in_item_t in_item,
  output logic                    res_valid,
  output fidtlv_pkg::result_t     res_item
);

  // parse state
  logic [8:0]  pos,   pos_next;
  logic [7:0]  len,   len_next;
  logic [9:0]  nhp,   nhp_next;
  logic [7:0]  rtype, rtype_next;
  logic [7:0]  rlen,  rlen_next;
  logic [9:0]  rvs,   rvs_next;
  logic [31:0] recent, recent_next;
  logic [2:0]  cdown      [fidtlv_pkg::CAPTURE_TYPES];
  logic [2:0]  cdown_next [fidtlv_pkg::CAPTURE_TYPES];
  logic [31:0] wide       [fidtlv_pkg::FIELD_SLOTS];
  logic [31:0] wide_next  [fidtlv_pkg::FIELD_SLOTS];
  logic [15:0] narrow      [fidtlv_pkg::FIELD_SLOTS];
  logic [15:0] narrow_next [fidtlv_pkg::FIELD_SLOTS];

  // working values
  logic        clr;
  logic        skip;
  logic [8:0]  p;
  logic [9:0]  p10;
  logic [7:0]  b;
  logic [7:0]  c_len;
  logic [9:0]  c_nhp;
  logic [7:0]  c_rtype;
  logic [7:0]  c_rlen;
  logic [9:0]  c_rvs;
  logic [7:0]  l_eff;
  logic [9:0]  off;
  logic [2:0]  cd;
  logic [2:0]  cap_k;
  logic        is_char;
  logic        is_sum;

  // next state and classification of the beat
  always_comb begin
    b       = in_item.data_byte;
    clr     = in_item.start_of_element || (pos == 9'd0);
    p       = clr ? 9'd0 : pos;
    p10     = {1'b0, p};
    c_len   = clr ? 8'd0 : len;
    c_nhp   = clr ? 10'(fidtlv_pkg::FIRST_HEADER) : nhp;
    c_rtype = clr ? 8'd0 : rtype;
    c_rlen  = clr ? 8'd0 : rlen;
    c_rvs   = clr ? 10'd0 : rvs;
    skip    = (p >= 9'd2) && (p10 > {2'b0, c_len} + 10'd1);
    l_eff   = (p == 9'd1) ? b : c_len;
    off     = p10 - c_rvs;
    cap_k   = 3'(c_rtype - fidtlv_pkg::REC_FIRST_CAPTURE);
    is_char = 1'b0;
    is_sum  = 1'b0;
    cd      = 3'd0;

    pos_next    = pos;
    len_next    = len;
    nhp_next    = nhp;
    rtype_next  = rtype;
    rlen_next   = rlen;
    rvs_next    = rvs;
    recent_next = recent;
    for (int k = 0; k < fidtlv_pkg::CAPTURE_TYPES; k++) cdown_next[k] = cdown[k];
    for (int s = 0; s < fidtlv_pkg::FIELD_SLOTS; s++) begin
      wide_next[s]   = wide[s];
      narrow_next[s] = narrow[s];
    end

    res_item            = '0;
    res_item.kind       = fidtlv_pkg::KIND_OPERATOR_CHAR;
    res_item.char_value = b;
    res_item.char_index = off[4:0];

    if (in_valid && !skip) begin
      // start from the cleared state at index 0
      len_next    = c_len;
      nhp_next    = c_nhp;
      rtype_next  = c_rtype;
      rlen_next   = c_rlen;
      rvs_next    = c_rvs;
      recent_next = {(clr ? 24'd0 : recent[23:0]), b};
      for (int s = 0; s < fidtlv_pkg::FIELD_SLOTS; s++) begin
        wide_next[s]   = clr ? 32'd0 : wide[s];
        narrow_next[s] = clr ? 16'd0 : narrow[s];
      end

      // countdown per field type, capture on the last byte
      for (int k = 0; k < fidtlv_pkg::CAPTURE_TYPES; k++) begin
        cd = clr ? 3'd0 : cdown[k];
        cdown_next[k] = cd;
        if (cd != 3'd0) begin
          cdown_next[k] = cd - 3'd1;
          if (cd == 3'd1) begin
            if (fidtlv_pkg::cap_wide(3'(k)))
              wide_next[fidtlv_pkg::cap_slot(3'(k))] = recent_next;
            else if (fidtlv_pkg::cap_size(3'(k)) == 3'd1)
              narrow_next[fidtlv_pkg::cap_slot(3'(k))] = {8'd0, b};
            else
              narrow_next[fidtlv_pkg::cap_slot(3'(k))] = recent_next[15:0];
          end
        end
      end

      len_next = l_eff;

      // id characters inside an id record
      if ((c_rtype == fidtlv_pkg::REC_OPERATOR_ID || c_rtype == fidtlv_pkg::REC_UAV_ID) &&
          (p10 >= c_rvs) && (off < {2'b0, c_rlen})) begin
        if (c_rtype == fidtlv_pkg::REC_OPERATOR_ID &&
            off >= 10'(fidtlv_pkg::ID_CHAR_OFFSET) &&
            (off - 10'(fidtlv_pkg::ID_CHAR_OFFSET)) < 10'(fidtlv_pkg::MAX_ID_CHARS)) begin
          is_char             = 1'b1;
          res_item.kind       = fidtlv_pkg::KIND_OPERATOR_CHAR;
          res_item.char_index = 5'(off - 10'(fidtlv_pkg::ID_CHAR_OFFSET));
        end else if (c_rtype == fidtlv_pkg::REC_UAV_ID &&
                     off < 10'(fidtlv_pkg::MAX_ID_CHARS)) begin
          is_char             = 1'b1;
          res_item.kind       = fidtlv_pkg::KIND_UAV_CHAR;
          res_item.char_index = off[4:0];
        end
      end

      // record header: type byte then length byte
      if (p10 == c_nhp && p < {1'b0, l_eff}) begin
        rtype_next = b;
      end else if ({1'b0, p10} == {1'b0, c_nhp} + 11'd1 && c_nhp < {2'b0, l_eff}) begin
        rlen_next = b;
        rvs_next  = p10 + 10'd1;
        nhp_next  = p10 + 10'd1 + {2'b0, b};
        if (c_rtype >= fidtlv_pkg::REC_FIRST_CAPTURE &&
            c_rtype <= fidtlv_pkg::REC_LAST_CAPTURE)
          cdown_next[cap_k] = fidtlv_pkg::cap_size(cap_k);
      end

      // summary on the last byte drops pending captures
      if (p >= 9'd1 && p == {1'b0, l_eff} + 9'd1) begin
        is_sum = 1'b1;
        for (int k = 0; k < fidtlv_pkg::CAPTURE_TYPES; k++) cdown_next[k] = 3'd0;
      end

      pos_next = p + 9'd1;
    end

    if (is_sum) begin
      res_item.kind          = fidtlv_pkg::KIND_SUMMARY;
      res_item.char_index    = 5'd0;
      res_item.char_value    = 8'd0;
      res_item.uav_lat       = wide_next[0];
      res_item.uav_lon       = wide_next[1];
      res_item.operator_lat  = wide_next[2];
      res_item.operator_long = wide_next[3];
      res_item.altitude      = narrow_next[0];
      res_item.height        = narrow_next[1];
      res_item.ground_speed  = narrow_next[2][7:0];
      res_item.course        = narrow_next[3];
    end
    res_valid = is_sum || is_char;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= 9'd0;
      len    <= 8'd0;
      nhp    <= 10'(fidtlv_pkg::FIRST_HEADER);
      rtype  <= 8'd0;
      rlen   <= 8'd0;
      rvs    <= 10'd0;
      recent <= 32'd0;
      for (int k = 0; k < fidtlv_pkg::CAPTURE_TYPES; k++) cdown[k] <= 3'd0;
      for (int s = 0; s < fidtlv_pkg::FIELD_SLOTS; s++) begin
        wide[s]   <= 32'd0;
        narrow[s] <= 16'd0;
      end
    end else begin
      pos    <= pos_next;
      len    <= len_next;
      nhp    <= nhp_next;
      rtype  <= rtype_next;
      rlen   <= rlen_next;
      rvs    <= rvs_next;
      recent <= recent_next;
      for (int k = 0; k < fidtlv_pkg::CAPTURE_TYPES; k++) cdown[k] <= cdown_next[k];
      for (int s = 0; s < fidtlv_pkg::FIELD_SLOTS; s++) begin
        wide[s]   <= wide_next[s];
        narrow[s] <= narrow_next[s];
      end
    end
  end

  // position never runs past the byte after the summary
  assert property (@(posedge clk) disable iff (rst) pos <= 9'd257)
    else $error("byte position past end of longest element");

  // a summary leaves the position just past the element
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind == fidtlv_pkg::KIND_SUMMARY |=> pos == {1'b0, len} + 9'd2)
    else $error("summary not on the last byte of the element");

  // character beats stay inside the id window
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind != fidtlv_pkg::KIND_SUMMARY |->
      res_item.char_index < 5'(fidtlv_pkg::MAX_ID_CHARS))
    else $error("id character index out of range");

endmodule
`default_nettype wire

/* hw/rtl/fidtlv_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fidtlv_queue
// Result queue between the parser and the consumer; the head entry is
// presented on the result side while the queue is not empty.
// ----------------------------------------------------------------------------
module fidtlv_queue #(
  parameter int DEPTH = fidtlv_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr,
  input  wire fidtlv_pkg::result_t wr_item,
  input  wire logic                rd,
  output fidtlv_pkg::result_t      rd_item,
  output logic                     empty,
  output logic                     full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fidtlv_pkg::result_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          do_wr;
  logic          do_rd;

  // pointer and fill count update
  always_comb begin
    do_wr       = wr && !full;
    do_rd       = rd && !empty;
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_wr) wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
    if (do_rd) rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
    if (do_wr && !do_rd) count_next = count + CW'(1);
    else if (do_rd && !do_wr) count_next = count - CW'(1);
  end

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign rd_item = entries[rd_ptr];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_item;
  end

  // fill count bounded by the depth
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  // a beat written into an empty queue shows up on the head next cycle
  assert property (@(posedge clk) disable iff (rst) do_wr && empty && !do_rd |=> !empty)
    else $error("written beat lost");

  // pointers agree with the count when the queue drains
  assert property (@(posedge clk) disable iff (rst) empty |-> rd_ptr == wr_ptr)
    else $error("queue pointers out of step");

endmodule
`default_nettype wire

/* dv/tb_french_remote_id_tlv_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_french_remote_id_tlv_parser
// Streams remote id vendor elements through the parser byte by byte. A
// parse model in the bench decodes each accepted byte into the id character
// and summary beats it should cause. Every beat that pops out is compared
// field by field, in order. The elements are short directed ones, then
// random well-formed elements with truncated, broken and noise traffic
// mixed in, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_french_remote_id_tlv_parser;

  // field record types captured into the summary
  localparam logic [7:0] REC_UAV_LAT  = 8'd4;
  localparam logic [7:0] REC_UAV_LON  = 8'd5;
  localparam logic [7:0] REC_ALTITUDE = 8'd6;
  localparam logic [7:0] REC_HEIGHT   = 8'd7;
  localparam logic [7:0] REC_OP_LAT   = 8'd8;
  localparam logic [7:0] REC_OP_LONG  = 8'd9;
  localparam logic [7:0] REC_SPEED    = 8'd10;
  localparam logic [7:0] REC_COURSE   = 8'd11;

  localparam int STALL_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 850;

  // element without a start flag right after reset, length zero
  localparam logic [15:0] ELEM_NO_START = {8'hFF, 8'h00};
  // short uav_lat record whose capture runs over the uav id header, uav and
  // operator id characters, and an operator latitude cut off by the end
  localparam logic [8*27-1:0] ELEM_MIXED = {
    8'h00, 8'd25, 8'hFF, 8'h00, 8'h55, 8'hAA,
    REC_UAV_LAT, 8'd1, 8'h7F,
    fidtlv_pkg::REC_UAV_ID, 8'd2, 8'hFF, 8'h00,
    fidtlv_pkg::REC_OPERATOR_ID, 8'd8, 8'h20, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
    8'h00, 8'hFF,
    REC_OP_LAT, 8'd4, 8'h80,
    8'h12
  };
  // course record whose capture runs over a second course record header
  localparam logic [8*12-1:0] ELEM_RESTART = {
    8'hFF, 8'd10, 8'h01, 8'h02, 8'h04, 8'h08,
    REC_COURSE, 8'd0, REC_COURSE, 8'd1, 8'hFF, 8'h00
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  fidtlv_pkg::in_item_t element_byte = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  fidtlv_pkg::result_t  result_beat;

  // stimulus and expected beats
  fidtlv_pkg::in_item_t byte_stream[$];
  fidtlv_pkg::result_t  decoded_beats[$];
  int       queued_items = 0;
  int       bytes_accepted = 0;
  int       failures = 0;
  int       idle_cycles = 0;
  int       tx_gap = 0;
  int       tx_calm = 0;
  int       rx_gap = 0;
  int       rx_calm = 0;
  logic     rx_hold = 1'b0;

  // parse state of the model
  logic [8:0]  elem_pos;
  logic [7:0]  elem_len;
  logic [9:0]  hdr_pos;
  logic [7:0]  tlv_type;
  logic [7:0]  tlv_len;
  logic [9:0]  value_start;
  logic [31:0] byte_window;
  logic [2:0]  capture_left [fidtlv_pkg::CAPTURE_TYPES];
  fidtlv_pkg::result_t field_set;

  french_remote_id_tlv_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .element_byte (element_byte),
    .empty        (empty),
    .pop          (pop),
    .result       (result_beat)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  // value bytes a field record takes whatever its declared length
  function automatic logic [2:0] field_bytes(input logic [7:0] rec);
    logic [2:0] n;
    case (rec)
      REC_UAV_LAT, REC_UAV_LON, REC_OP_LAT, REC_OP_LONG: n = 3'd4;
      REC_SPEED: n = 3'd1;
      default: n = 3'd2;
    endcase
    return n;
  endfunction

  function void clear_parse_state();
    elem_pos = '0;
    elem_len = '0;
    hdr_pos = 10'(fidtlv_pkg::FIRST_HEADER);
    tlv_type = '0;
    tlv_len = '0;
    value_start = '0;
    byte_window = '0;
    for (int k = 0; k < fidtlv_pkg::CAPTURE_TYPES; k++) capture_left[k] = '0;
    field_set = '0;
  endfunction

  // decode one accepted byte, queue the beat it causes if any
  function void parse_element_byte(input fidtlv_pkg::in_item_t beat);
    int                  p;
    int                  off;
    int                  k;
    logic [7:0]          b;
    logic                emit;
    fidtlv_pkg::result_t r;
    b = beat.data_byte;
    emit = 1'b0;
    r = '0;
    if (beat.start_of_element || elem_pos == 0) begin
      clear_parse_state();
      p = 0;
    end else begin
      p = int'(elem_pos);
    end
    // bytes past the end of the element are dropped
    if (p >= 2 && p > int'(elem_len) + 1) return;

    byte_window = {byte_window[23:0], b};

    // finish pending big-endian captures
    for (k = 0; k < fidtlv_pkg::CAPTURE_TYPES; k++) begin
      if (capture_left[k] != 0) begin
        capture_left[k] = capture_left[k] - 3'd1;
        if (capture_left[k] == 0) begin
          case (8'(k) + fidtlv_pkg::REC_FIRST_CAPTURE)
            REC_UAV_LAT:  field_set.uav_lat = byte_window;
            REC_UAV_LON:  field_set.uav_lon = byte_window;
            REC_ALTITUDE: field_set.altitude = byte_window[15:0];
            REC_HEIGHT:   field_set.height = byte_window[15:0];
            REC_OP_LAT:   field_set.operator_lat = byte_window;
            REC_OP_LONG:  field_set.operator_long = byte_window;
            REC_SPEED:    field_set.ground_speed = b;
            default:      field_set.course = byte_window[15:0];
          endcase
        end
      end
    end

    if (p == 1) elem_len = b;

    // id characters inside the current record value
    if ((tlv_type == fidtlv_pkg::REC_OPERATOR_ID || tlv_type == fidtlv_pkg::REC_UAV_ID) &&
        p >= int'(value_start)) begin
      off = p - int'(value_start);
      if (off < int'(tlv_len)) begin
        if (tlv_type == fidtlv_pkg::REC_OPERATOR_ID && off >= fidtlv_pkg::ID_CHAR_OFFSET &&
            off - fidtlv_pkg::ID_CHAR_OFFSET < fidtlv_pkg::MAX_ID_CHARS) begin
          r.kind = fidtlv_pkg::KIND_OPERATOR_CHAR;
          r.char_index = 5'(off - fidtlv_pkg::ID_CHAR_OFFSET);
          r.char_value = b;
          emit = 1'b1;
        end else if (tlv_type == fidtlv_pkg::REC_UAV_ID && off < fidtlv_pkg::MAX_ID_CHARS) begin
          r.kind = fidtlv_pkg::KIND_UAV_CHAR;
          r.char_index = 5'(off);
          r.char_value = b;
          emit = 1'b1;
        end
      end
    end

    // record header walk
    if (p == int'(hdr_pos) && p < int'(elem_len)) begin
      tlv_type = b;
    end else if (p == int'(hdr_pos) + 1 && int'(hdr_pos) < int'(elem_len)) begin
      tlv_len = b;
      value_start = 10'(p + 1);
      hdr_pos = 10'(p + 1 + int'(b));
      if (tlv_type >= fidtlv_pkg::REC_FIRST_CAPTURE && tlv_type <= fidtlv_pkg::REC_LAST_CAPTURE)
        capture_left[3'(tlv_type - fidtlv_pkg::REC_FIRST_CAPTURE)] = field_bytes(tlv_type);
    end

    // last byte of the element: summary wins over a character
    if (p >= 1 && p == int'(elem_len) + 1) begin
      for (k = 0; k < fidtlv_pkg::CAPTURE_TYPES; k++) capture_left[k] = '0;
      r = field_set;
      r.kind = fidtlv_pkg::KIND_SUMMARY;
      r.char_index = '0;
      r.char_value = '0;
      emit = 1'b1;
    end

    elem_pos = 9'(p + 1);
    if (emit) decoded_beats.push_back(r);
  endfunction

  // gap before the next beat: mostly short, a few long, some calm stretches
  function automatic int draw_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  task automatic add_item(input logic [7:0] d, input logic sof, input bit counts);
    fidtlv_pkg::in_item_t it;
    it.data_byte = d;
    it.start_of_element = sof;
    byte_stream.push_back(it);
    if (counts) queued_items++;
  endtask

  task automatic queue_bytes(input logic [511:0] bytes, input int count, input logic with_start);
    int i;
    for (i = 0; i < count; i++)
      add_item(bytes[8*(count-1-i) +: 8], with_start && i == 0, 1'b1);
  endtask

  // one random element of tlv records, possibly with an odd length or cut off
  task automatic queue_element(input bit cut_short);
    logic [7:0] body[$];
    logic [7:0] rtype;
    logic [7:0] d;
    int         rlen;
    int         target;
    int         natural_len;
    int         len_byte;
    int         total;
    int         r;
    int         i;
    target = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 249) : $urandom_range(0, 40);
    while (body.size() < target) begin
      r = $urandom_range(0, 19);
      if (r < 3) begin
        rtype = fidtlv_pkg::REC_OPERATOR_ID;
        rlen = fidtlv_pkg::ID_CHAR_OFFSET + $urandom_range(0, 24);
      end else if (r < 6) begin
        rtype = fidtlv_pkg::REC_UAV_ID;
        rlen = $urandom_range(0, 24);
      end else if (r < 18) begin
        rtype = 8'($urandom_range(fidtlv_pkg::REC_FIRST_CAPTURE, fidtlv_pkg::REC_LAST_CAPTURE));
        rlen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : int'(field_bytes(rtype));
      end else begin
        rtype = 8'($urandom);
        rlen = $urandom_range(0, 8);
      end
      body.push_back(rtype);
      body.push_back(8'(rlen));
      // value bytes lean toward sign and range extremes
      repeat (rlen) begin
        case ($urandom_range(0, 7))
          0: d = 8'h00;
          1: d = 8'hFF;
          2: d = 8'h80;
          3: d = 8'h7F;
          default: d = 8'($urandom);
        endcase
        body.push_back(d);
      end
    end

    natural_len = fidtlv_pkg::FIRST_HEADER + body.size();
    if (natural_len > 255) natural_len = 255;
    r = $urandom_range(0, 9);
    if (r == 7) len_byte = $urandom_range(0, natural_len);
    else if (r == 8) len_byte = natural_len + $urandom_range(1, 20);
    else if (r == 9) len_byte = $urandom_range(0, fidtlv_pkg::FIRST_HEADER);
    else len_byte = natural_len;
    if (len_byte > 255) len_byte = 255;

    total = len_byte + 2;
    if (cut_short) total = $urandom_range(1, total - 1);
    for (i = 0; i < total; i++) begin
      if (i == 1) d = 8'(len_byte);
      else if (i >= fidtlv_pkg::FIRST_HEADER && i - fidtlv_pkg::FIRST_HEADER < body.size())
        d = body[i - fidtlv_pkg::FIRST_HEADER];
      else d = 8'($urandom);
      add_item(d, i == 0, 1'b1);
    end
    // trailing bytes the parser ignores
    if (!cut_short && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) add_item(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic queue_random_traffic(input int item_goal);
    int stop_at;
    int r;
    stop_at = queued_items + item_goal;
    while (queued_items < stop_at) begin
      r = $urandom_range(0, 19);
      if (r < 16) queue_element(1'b0);
      else if (r < 18) queue_element(1'b1);
      else repeat ($urandom_range(1, 8)) add_item(8'($urandom), $urandom_range(0, 3) == 0, 1'b1);
    end
  endtask

  // sender idles until every byte is in and every beat is out
  task automatic wait_drained();
    @(negedge clk);
    while (byte_stream.size() != 0 || push || decoded_beats.size() != 0) @(negedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_gap = 0;
      clear_parse_state();
    end else begin
      if (push && !full) begin
        parse_element_byte(element_byte);
        bytes_accepted++;
      end
      if (!(push && full)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          element_byte <= byte_stream.pop_front();
          push <= 1'b1;
          tx_gap = draw_gap(tx_calm);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result consumer
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_gap = 0;
    end else if (rx_hold) begin
      pop <= 1'b0;
    end else if (!(pop && empty)) begin
      if (pop && !empty) rx_gap = draw_gap(rx_calm);
      if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // compare each popped beat with the oldest decoded one
  always @(posedge clk) begin
    fidtlv_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (decoded_beats.size() == 0) begin
        failures++;
        $error("result beat with nothing pending, kind %0d", result_beat.kind);
      end else begin
        want = decoded_beats.pop_front();
        check_field("kind", 32'(want.kind), 32'(result_beat.kind));
        check_field("char_index", 32'(want.char_index), 32'(result_beat.char_index));
        check_field("char_value", 32'(want.char_value), 32'(result_beat.char_value));
        check_field("uav_lat", want.uav_lat, result_beat.uav_lat);
        check_field("uav_lon", want.uav_lon, result_beat.uav_lon);
        check_field("operator_lat", want.operator_lat, result_beat.operator_lat);
        check_field("operator_long", want.operator_long, result_beat.operator_long);
        check_field("altitude", 32'(want.altitude), 32'(result_beat.altitude));
        check_field("height", 32'(want.height), 32'(result_beat.height));
        check_field("ground_speed", 32'(want.ground_speed), 32'(result_beat.ground_speed));
        check_field("course", 32'(want.course), 32'(result_beat.course));
      end
    end
  end

  // cycles without any beat moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // consumer stops for a long stretch so the result queue fills and full rises
  initial begin
    @(negedge clk);
    while (bytes_accepted < 400) @(negedge clk);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // stimulus
  initial begin
    queue_bytes(512'(ELEM_NO_START), 2, 1'b0);
    add_item(8'hAA, 1'b0, 1'b0);
    queue_bytes(512'(ELEM_MIXED), 27, 1'b1);
    queue_bytes(512'(ELEM_RESTART), 12, 1'b1);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait_drained();
    queue_random_traffic(RANDOM_ITEMS);
    wait_drained();
    queue_random_traffic(RANDOM_ITEMS);
    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0 && decoded_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
